>>> design/gcd_pkg.sv
package gcd_pkg;

  // Field widths
  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 26;
  localparam int RAD_W  = 24;

  // Angle scale: degrees with this many fraction bits
  localparam int ANGLE_FRAC_BITS = 16;

  // Internal fractions are Q30
  localparam int QBITS     = 30;
  localparam int QW        = 32;
  localparam int CW        = 36;
  localparam int ROOT_BITS = QBITS + 1;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [QW-1:0] q_t;

  localparam cw_t ONE_Q  = 36'sd1073741824;
  localparam cw_t GAIN_Q = 36'sd652032874;

  // pi in Q30 split as 180 * PI_QUO + PI_REM
  localparam logic [24:0] PI_QUO = 25'd18740330;
  localparam logic [4:0]  PI_REM = 5'd26;

  // floor(2^RECIP_SH / 90) for the divide by 90
  localparam logic [27:0] RECIP90  = 28'd190887435;
  localparam int          RECIP_SH = 34;

  localparam logic [DIST_W:0] DIST_MAX     = 27'd67108863;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 24'd1630720;

  // Register map
  localparam int PADDR_W = 3;
  localparam logic REG_RADIUS = 1'b0;

  // atan(2^-i) in Q30 radians, truncated
  localparam cw_t ATAN_Q [32] = '{
    36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
    36'sd67021686,  36'sd33543515,  36'sd16775850,  36'sd8388437,
    36'sd4194282,   36'sd2097149,   36'sd1048575,   36'sd524287,
    36'sd262143,    36'sd131071,    36'sd65535,     36'sd32767,
    36'sd16383,     36'sd8191,      36'sd4095,      36'sd2047,
    36'sd1023,      36'sd511,       36'sd255,       36'sd127,
    36'sd63,        36'sd31,        36'sd15,        36'sd7,
    36'sd3,         36'sd1,         36'sd0,         36'sd0
  };

endpackage

>>> design/gcd_if.sv
interface gcd_query_if;
  logic                               valid;
  logic                               ready;
  logic signed [gcd_pkg::LAT_W-1:0]   lat_from;
  logic signed [gcd_pkg::LON_W-1:0]   lon_from;
  logic signed [gcd_pkg::LAT_W-1:0]   lat_to;
  logic signed [gcd_pkg::LON_W-1:0]   lon_to;

  modport source  (output valid, lat_from, lon_from, lat_to, lon_to, input ready);
  modport sink    (input valid, lat_from, lon_from, lat_to, lon_to, output ready);
  modport monitor (input valid, ready, lat_from, lon_from, lat_to, lon_to);
endinterface

interface gcd_result_if;
  logic                        valid;
  logic                        ready;
  logic [gcd_pkg::DIST_W-1:0]  distance;

  modport source  (output valid, distance, input ready);
  modport sink    (input valid, distance, output ready);
  modport monitor (input valid, ready, distance);
endinterface

>>> design/great_circle_distance.sv
// Channel   Dir  Fields                                  Handshake
// query     in   lat_from, lon_from, lat_to, lon_to      valid / ready
// result    out  distance                                valid / ready
// apb       in   sphere_radius at byte address 0         psel / penable, pready
//
// One item enters per clock while the pipeline is not stalled; the pipeline holds
// the two pipelined CORDIC units and the 31-stage square root.
// Reset (rst, synchronous) empties the pipeline and loads the 6370 km radius.
// A two-entry output buffer holds results; the whole pipeline stalls only
// when both entries are full, and then query.ready drops.
module great_circle_distance #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  gcd_query_if.sink                     query,
  gcd_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW  = 27;
  localparam int MW  = 24;
  localparam int PW  = 49;
  localparam int TW  = 28;
  localparam int EW  = 22;
  localparam int F   = gcd_pkg::ANGLE_FRAC_BITS;
  localparam int RB  = gcd_pkg::ROOT_BITS;
  localparam logic signed [AW-1:0] HALF_D = AW'(180 << (F + 1));
  localparam logic signed [AW-1:0] HALF_L = AW'(180 << F);

  // ---------------- configuration ----------------
  logic [gcd_pkg::RAD_W-1:0] radius;
  logic                      reg_idx;
  logic                      cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[gcd_pkg::PADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (reg_idx == gcd_pkg::REG_RADIUS) ? 32'(radius) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_wr && reg_idx == gcd_pkg::REG_RADIUS) begin
      radius <= pwdata[gcd_pkg::RAD_W-1:0];
    end
  end

  // ---------------- pipeline enable ----------------
  logic [1:0] cnt;
  logic       en;

  assign en          = (cnt != 2'd2);
  assign query.ready = en;

  function automatic logic signed [AW-1:0] half_of(input int l);
    return (l < 2) ? HALF_D : HALF_L;
  endfunction

  function automatic gcd_pkg::q_t clampq(input gcd_pkg::cw_t v);
    if (v > gcd_pkg::ONE_Q) begin
      return gcd_pkg::q_t'(gcd_pkg::ONE_Q);
    end else if (v < -gcd_pkg::ONE_Q) begin
      return -gcd_pkg::q_t'(gcd_pkg::ONE_Q);
    end
    return v[gcd_pkg::QW-1:0];
  endfunction

  function automatic gcd_pkg::q_t mulq(input gcd_pkg::q_t a, input gcd_pkg::q_t b);
    logic signed [2*gcd_pkg::QW-1:0] p;
    p = a * b;
    return p[gcd_pkg::QBITS+gcd_pkg::QW-1:gcd_pkg::QBITS];
  endfunction

  // ---------------- s0: capture item ----------------
  logic                             v0;
  logic signed [gcd_pkg::LAT_W-1:0] laf0, lat0;
  logic signed [gcd_pkg::LON_W-1:0] lof0, lot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      laf0 <= query.lat_from;
      lof0 <= query.lon_from;
      lat0 <= query.lat_to;
      lot0 <= query.lon_to;
    end
  end

  // ---------------- s1: differences, wrap into [-180,180) ----------------
  // lanes: 0 half lat diff, 1 half lon diff, 2 lat_from, 3 lat_to
  logic                   v1;
  logic signed [AW-1:0]   ang [4];
  logic signed [AW-1:0]   wrp [4];
  logic signed [AW-1:0]   r1  [4];

  always_comb begin
    ang[0] = AW'(lat0) - AW'(laf0);
    ang[1] = AW'(lot0) - AW'(lof0);
    ang[2] = AW'(laf0);
    ang[3] = AW'(lat0);
    for (int l = 0; l < 4; l++) begin
      if (ang[l] >= half_of(l)) begin
        wrp[l] = ang[l] - (half_of(l) <<< 1);
      end else if (ang[l] < -half_of(l)) begin
        wrp[l] = ang[l] + (half_of(l) <<< 1);
      end else begin
        wrp[l] = ang[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= wrp;
    end
  end

  // ---------------- s2: fold into [-90,90], take magnitude ----------------
  logic                 v2;
  logic signed [AW-1:0] fld [4];
  logic [3:0]           flp;
  logic [MW-1:0]        mag2 [4];
  logic [3:0]           neg2;
  logic [1:0]           flip2;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (r1[l] > (half_of(l) >>> 1)) begin
        fld[l] = half_of(l) - r1[l];
        flp[l] = 1'b1;
      end else if (r1[l] < -(half_of(l) >>> 1)) begin
        fld[l] = -half_of(l) - r1[l];
        flp[l] = 1'b1;
      end else begin
        fld[l] = r1[l];
        flp[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        mag2[l] <= (fld[l] < 0) ? MW'(-fld[l]) : MW'(fld[l]);
        neg2[l] <= fld[l] < 0;
      end
      flip2 <= flp[3:2];
    end
  end

  // ---------------- s3: |r| * (pi/180) quotient part, and 13|r| ----------------
  logic          v3;
  logic [PW-1:0] prod3 [4];
  logic [TW-1:0] t13_3 [4];
  logic [3:0]    neg3;
  logic [1:0]    flip3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        prod3[l] <= PW'(mag2[l]) * PW'(gcd_pkg::PI_QUO);
        t13_3[l] <= TW'(mag2[l]) * TW'(gcd_pkg::PI_REM >> 1);
      end
      neg3  <= neg2;
      flip3 <= flip2;
    end
  end

  // ---------------- s4: estimate 13|r| / 90 by reciprocal ----------------
  logic              v4;
  logic [2*TW-1:0]   rprod [4];
  logic [EW-1:0]     est4  [4];
  logic [TW-1:0]     t13_4 [4];
  logic [PW-1:0]     prod4 [4];
  logic [3:0]        neg4;
  logic [1:0]        flip4;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rprod[l] = (2*TW)'(t13_3[l]) * (2*TW)'(gcd_pkg::RECIP90);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        est4[l]  <= rprod[l][gcd_pkg::RECIP_SH +: EW];
        t13_4[l] <= t13_3[l];
        prod4[l] <= prod3[l];
      end
      neg4  <= neg3;
      flip4 <= flip3;
    end
  end

  // ---------------- s5: correct the quotient by one ----------------
  logic            v5;
  logic [TW:0]     rem5 [4];
  logic [EW-1:0]   q5   [4];
  logic [PW-1:0]   prod5 [4];
  logic [3:0]      neg5;
  logic [1:0]      flip5;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rem5[l] = (TW+1)'(t13_4[l]) - (TW+1)'(est4[l]) * (TW+1)'(7'd90);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        q5[l]    <= est4[l] + EW'(rem5[l] >= (TW+1)'(90));
        prod5[l] <= prod4[l];
      end
      neg5  <= neg4;
      flip5 <= flip4;
    end
  end

  // ---------------- s6: scale to Q30 radians, apply sign ----------------
  logic               v6;
  logic [PW:0]        sum6 [4];
  logic [31:0]        zmag [4];
  gcd_pkg::cw_t       z6   [4];
  logic [1:0]         flip6;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sum6[l] = (PW+1)'(prod5[l]) + (PW+1)'(q5[l]);
      zmag[l] = (l < 2) ? sum6[l][F+1 +: 32] : sum6[l][F +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        z6[l] <= neg5[l] ? -gcd_pkg::cw_t'({4'b0, zmag[l]})
                         :  gcd_pkg::cw_t'({4'b0, zmag[l]});
      end
      flip6 <= flip5;
    end
  end

  // ---------------- rotation CORDIC, four lanes ----------------
  gcd_pkg::cw_t rx_in [4];
  gcd_pkg::cw_t ry_in [4];
  gcd_pkg::cw_t rx    [4];
  gcd_pkg::cw_t ry    [4];
  gcd_pkg::cw_t rz    [4];
  logic         vrot;
  logic [1:0]   fd [CORDIC_STAGES+1];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rx_in[l] = gcd_pkg::GAIN_Q;
      ry_in[l] = '0;
    end
  end

  gcd_cordic #(
    .STAGES (CORDIC_STAGES),
    .LANES  (4),
    .VECTOR (1'b0)
  ) u_rot (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (v6),
    .x_in    (rx_in),
    .y_in    (ry_in),
    .z_in    (z6),
    .vld_out (vrot),
    .x_out   (rx),
    .y_out   (ry),
    .z_out   (rz)
  );

  // carry the cosine fold flags alongside the CORDIC
  assign fd[0] = flip6;
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_fd
    always_ff @(posedge clk) begin
      if (en) begin
        fd[i+1] <= fd[i];
      end
    end
  end

  // ---------------- s7: clamp sin/cos ----------------
  logic        v7;
  gcd_pkg::q_t sdl7, sdo7, c1_7, c2_7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= vrot;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdl7 <= clampq(ry[0]);
      sdo7 <= clampq(ry[1]);
      c1_7 <= fd[CORDIC_STAGES][0] ? -clampq(rx[2]) : clampq(rx[2]);
      c2_7 <= fd[CORDIC_STAGES][1] ? -clampq(rx[3]) : clampq(rx[3]);
    end
  end

  // ---------------- s8: squares and cosine product ----------------
  logic        v8;
  gcd_pkg::q_t pdl8, pc8, pdo8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pdl8 <= mulq(sdl7, sdl7);
      pc8  <= mulq(c1_7, c2_7);
      pdo8 <= mulq(sdo7, sdo7);
    end
  end

  // ---------------- s9: cos*cos*sin^2 ----------------
  logic        v9;
  gcd_pkg::q_t pdl9, p2_9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pdl9 <= pdl8;
      p2_9 <= mulq(pc8, pdo8);
    end
  end

  // ---------------- s10: a and 1-a, clamped ----------------
  logic                      v10;
  logic signed [gcd_pkg::QW:0] asum;
  logic [RB-1:0]             aclamp;
  logic [RB-1:0]             sq_in [2];

  always_comb begin
    asum = (gcd_pkg::QW+1)'(pdl9) + (gcd_pkg::QW+1)'(p2_9);
    if (asum < 0) begin
      aclamp = '0;
    end else if (asum > (gcd_pkg::QW+1)'(gcd_pkg::ONE_Q)) begin
      aclamp = RB'(gcd_pkg::ONE_Q);
    end else begin
      aclamp = asum[RB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_in[0] <= aclamp;
      sq_in[1] <= RB'(gcd_pkg::ONE_Q) - aclamp;
    end
  end

  // ---------------- square roots ----------------
  logic          vsq;
  logic [RB-1:0] roots [2];

  gcd_sqrt #(
    .LANES (2)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (v10),
    .val_in   (sq_in),
    .vld_out  (vsq),
    .root_out (roots)
  );

  // ---------------- vectoring CORDIC: atan2(sqrt a, sqrt(1-a)) ----------------
  gcd_pkg::cw_t vx_in [1];
  gcd_pkg::cw_t vy_in [1];
  gcd_pkg::cw_t vz_in [1];
  gcd_pkg::cw_t vx    [1];
  gcd_pkg::cw_t vy    [1];
  gcd_pkg::cw_t vz    [1];
  logic         vvec;

  assign vx_in[0] = gcd_pkg::cw_t'(roots[1]);
  assign vy_in[0] = gcd_pkg::cw_t'(roots[0]);
  assign vz_in[0] = '0;

  gcd_cordic #(
    .STAGES (CORDIC_STAGES),
    .LANES  (1),
    .VECTOR (1'b1)
  ) u_vec (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (vsq),
    .x_in    (vx_in),
    .y_in    (vy_in),
    .z_in    (vz_in),
    .vld_out (vvec),
    .x_out   (vx),
    .y_out   (vy),
    .z_out   (vz)
  );

  // ---------------- sm: 2R * theta ----------------
  logic              vm;
  logic [RB-1:0]     theta;
  logic [55:0]       m;

  assign theta = (vz[0] < 0) ? '0 : vz[0][RB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vvec;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m <= 56'({radius, 1'b0}) * 56'(theta);
    end
  end

  // ---------------- sd: round, saturate ----------------
  logic                      vd;
  logic [56:0]               rnd;
  logic [gcd_pkg::DIST_W:0]  dd;
  logic [gcd_pkg::DIST_W-1:0] d;

  assign rnd = 57'(m) + (57'(1) << (gcd_pkg::QBITS - 1));
  assign dd  = rnd[gcd_pkg::QBITS +: gcd_pkg::DIST_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d <= (dd > gcd_pkg::DIST_MAX) ? gcd_pkg::DIST_MAX[gcd_pkg::DIST_W-1:0]
                                    : dd[gcd_pkg::DIST_W-1:0];
    end
  end

  // ---------------- two-entry output buffer ----------------
  logic                       push, pop;
  logic [gcd_pkg::DIST_W-1:0] f0, f1;

  assign push            = en && vd;
  assign pop             = result.valid && result.ready;
  assign result.valid    = (cnt != 2'd0);
  assign result.distance = f0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  // hold, shift down on pop, fill the first free entry on push
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd1) begin
        f0 <= d;
      end else begin
        f0 <= f1;
        f1 <= d;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        f0 <= d;
      end else begin
        f1 <= d;
      end
    end else if (pop) begin
      f0 <= f1;
    end
  end

endmodule

>>> design/gcd_cordic.sv
module gcd_cordic #(
  parameter int STAGES = 24,
  parameter int LANES  = 1,
  parameter bit VECTOR = 1'b0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vld_in,
  input  gcd_pkg::cw_t x_in [LANES],
  input  gcd_pkg::cw_t y_in [LANES],
  input  gcd_pkg::cw_t z_in [LANES],
  output logic         vld_out,
  output gcd_pkg::cw_t x_out [LANES],
  output gcd_pkg::cw_t y_out [LANES],
  output gcd_pkg::cw_t z_out [LANES]
);

  gcd_pkg::cw_t xs [STAGES+1][LANES];
  gcd_pkg::cw_t ys [STAGES+1][LANES];
  gcd_pkg::cw_t zs [STAGES+1][LANES];
  logic [STAGES:0] vs;

  assign vs[0]   = vld_in;
  assign vld_out = vs[STAGES];

  for (genvar l = 0; l < LANES; l++) begin : g_io
    assign xs[0][l]  = x_in[l];
    assign ys[0][l]  = y_in[l];
    assign zs[0][l]  = z_in[l];
    assign x_out[l]  = xs[STAGES][l];
    assign y_out[l]  = ys[STAGES][l];
    assign z_out[l]  = zs[STAGES][l];
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    // advance the valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic ccw;

      // rotate toward zero angle, or toward the x axis when vectoring
      assign ccw = VECTOR ? !(ys[i][l] > 0) : (zs[i][l] >= 0);

      always_ff @(posedge clk) begin
        if (en) begin
          if (ccw) begin
            xs[i+1][l] <= xs[i][l] - (ys[i][l] >>> i);
            ys[i+1][l] <= ys[i][l] + (xs[i][l] >>> i);
            zs[i+1][l] <= zs[i][l] - gcd_pkg::ATAN_Q[i];
          end else begin
            xs[i+1][l] <= xs[i][l] + (ys[i][l] >>> i);
            ys[i+1][l] <= ys[i][l] - (xs[i][l] >>> i);
            zs[i+1][l] <= zs[i][l] + gcd_pkg::ATAN_Q[i];
          end
        end
      end
    end
  end

endmodule

>>> design/gcd_sqrt.sv
module gcd_sqrt #(
  parameter int LANES = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            vld_in,
  input  logic [gcd_pkg::ROOT_BITS-1:0]   val_in [LANES],
  output logic                            vld_out,
  output logic [gcd_pkg::ROOT_BITS-1:0]   root_out [LANES]
);

  localparam int RB = gcd_pkg::ROOT_BITS;
  localparam int RW = 2 * RB;

  logic [RW-1:0] rem  [RB+1][LANES];
  logic [RB-1:0] root [RB+1][LANES];
  logic [RB:0]   vs;

  assign vs[0]   = vld_in;
  assign vld_out = vs[RB];

  // radicand is the value shifted up by the fraction width
  for (genvar l = 0; l < LANES; l++) begin : g_io
    assign rem[0][l]   = RW'({val_in[l], {gcd_pkg::QBITS{1'b0}}});
    assign root[0][l]  = '0;
    assign root_out[l] = root[RB][l];
  end

  // one result bit per stage, most significant first
  for (genvar j = 0; j < RB; j++) begin : g_stage
    localparam int K = RB - 1 - j;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else if (en) begin
        vs[j+1] <= vs[j];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW-1:0] trial;

      assign trial = (RW'({root[j][l], 1'b0}) | (RW'(1) << K)) << K;

      always_ff @(posedge clk) begin
        if (en) begin
          if (rem[j][l] >= trial) begin
            rem[j+1][l]  <= rem[j][l] - trial;
            root[j+1][l] <= root[j][l] | (RB'(1) << K);
          end else begin
            rem[j+1][l]  <= rem[j][l];
            root[j+1][l] <= root[j][l];
          end
        end
      end
    end
  end

endmodule

>>> design/gcd_checker.sv
module gcd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        q_ready,
  input logic                        r_valid,
  input logic                        r_ready,
  input logic [gcd_pkg::DIST_W-1:0]  distance
);

  // a waiting item stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(distance))
    else $error("result item changed while stalled");

  // reset empties the output buffer
  a_rst: assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid right after reset");

  // input stalls only while results are waiting
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !q_ready |-> r_valid)
    else $error("query stalled with no result waiting");

  // a full buffer stays full until a result is taken
  a_full: assert property (@(posedge clk) disable iff (rst)
    !q_ready && !r_ready |=> !q_ready)
    else $error("buffer drained without a result taken");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
  .clk      (clk),
  .rst      (rst),
  .q_ready  (query.ready),
  .r_valid  (result.valid),
  .r_ready  (result.ready),
  .distance (result.distance)
);
